// ===== src/bkol_pkg.sv =====
// Shared types and constants for the bounded keyed ordered list.
package bkol_pkg;

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = 8;
    localparam int POS_CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int ECNT_W    = 5;

    typedef logic        [PAYLOAD_WIDTH-1:0] t_payload;
    typedef logic signed [31:0]              t_key;
    typedef logic        [CNT_W-1:0]         t_count;
    typedef logic        [IDX_W-1:0]         t_idx;

    typedef enum logic [3:0] {
        F_INS_FRONT  = 4'd0,
        F_INS_BACK   = 4'd1,
        F_INS_SORTED = 4'd2,
        F_REM_FRONT  = 4'd3,
        F_REM_BACK   = 4'd4,
        F_REM_KEY    = 4'd5,
        F_READ_POS   = 4'd6,
        F_READ_KEY   = 4'd7,
        F_HAS_KEY    = 4'd8,
        F_CLEAR      = 4'd9
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // what a cell does with its entry this cycle
    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_INS,
        MODE_REM
    } t_mode;

    // which condition marks a cell as the target
    typedef enum logic [2:0] {
        MARK_NONE,
        MARK_FRONT,
        MARK_TAIL,
        MARK_GE_TAIL,
        MARK_MATCH,
        MARK_POS
    } t_mark;

    typedef struct packed {
        t_mode              mode;
        t_mark              mark;
        t_count             count;
        t_key               key;
        t_payload           data;
        logic [POS_W-1:0]   pos;
    } t_cell_ctl;

endpackage

// ===== src/bkol_cell.sv =====
// One list cell: holds an entry, compares it and shifts with its neighbours.
module bkol_cell (
    input  logic               i_clk,
    input  bkol_pkg::t_idx     i_idx,
    input  bkol_pkg::t_cell_ctl i_ctl,
    input  logic               i_prior,
    input  bkol_pkg::t_key     i_left_key,
    input  bkol_pkg::t_payload i_left_data,
    input  bkol_pkg::t_key     i_right_key,
    input  bkol_pkg::t_payload i_right_data,
    output bkol_pkg::t_key     o_key,
    output bkol_pkg::t_payload o_data,
    output logic               o_prior,
    output logic               o_target
);

    bkol_pkg::t_key     r_key,  n_key;
    bkol_pkg::t_payload r_data, n_data;
    logic               occ, tail, ge, mark;
    logic [bkol_pkg::POS_CMP_W-1:0] my_pos;

    always_comb begin
        occ    = bkol_pkg::CNT_W'(i_idx) < i_ctl.count;
        tail   = bkol_pkg::CNT_W'(i_idx) == i_ctl.count;
        ge     = occ && !(r_key < i_ctl.key);
        my_pos = bkol_pkg::POS_CMP_W'(i_idx) + bkol_pkg::POS_CMP_W'(1);
        unique case (i_ctl.mark)
            bkol_pkg::MARK_FRONT:   mark = (i_idx == '0);
            bkol_pkg::MARK_TAIL:    mark = tail;
            bkol_pkg::MARK_GE_TAIL: mark = ge || tail;
            bkol_pkg::MARK_MATCH:   mark = occ && (r_key == i_ctl.key);
            bkol_pkg::MARK_POS:     mark = occ && (my_pos == bkol_pkg::POS_CMP_W'(i_ctl.pos));
            default:                mark = 1'b0;
        endcase
        o_target = mark && !i_prior;
        o_prior  = mark || i_prior;

        n_key  = r_key;
        n_data = r_data;
        unique case (i_ctl.mode)
            bkol_pkg::MODE_INS: begin
                if (o_target) begin
                    n_key  = i_ctl.key;
                    n_data = i_ctl.data;
                end else if (i_prior) begin
                    n_key  = i_left_key;
                    n_data = i_left_data;
                end
            end
            bkol_pkg::MODE_REM: begin
                if (o_prior) begin
                    n_key  = i_right_key;
                    n_data = i_right_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
    end

    assign o_key  = r_key;
    assign o_data = r_data;

endmodule

// ===== src/bounded_keyed_ordered_list.sv =====
// Top level of the bounded keyed ordered list: command capture, cell row and result.
//
//  channel  | handshake           | beat fields
//  ---------+---------------------+-------------------------------------------------
//  command  | start & !busy       | i_func, i_record_key, i_record_data, i_position
//  result   | o_valid (one cycle) | o_status, o_found_key, o_found_data,
//           |                     | o_entry_count, o_is_empty
//
// Every command is first registered at the accepting edge; then the cell row
// compares, shifts and answers in one pass in the working cycle. That pass is set
// by the first-target mark rippling along the row of DEPTH cells.
// The result strobe lies in the cycle after, together with the next acceptance.
// Reset clears the entry count, busy and valid; cell contents are undefined until written.
// The receiver cannot stall, so busy is high only in the working cycle.
module bounded_keyed_ordered_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_func,
    input  logic signed [31:0] i_record_key,
    input  logic [31:0] i_record_data,
    input  logic [7:0]  i_position,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic signed [31:0] o_found_key,
    output logic [31:0] o_found_data,
    output logic [4:0]  o_entry_count,
    output logic        o_is_empty
);

    localparam int DEPTH = bkol_pkg::DEPTH;

    // captured command beat
    logic                  r_busy;
    bkol_pkg::t_func       r_func;
    bkol_pkg::t_key        r_key;
    logic [31:0]           r_data;
    logic [7:0]            r_pos;
    bkol_pkg::t_count      r_count, n_count;

    // result registers
    logic                  r_valid;
    bkol_pkg::t_status     r_status, n_status;
    bkol_pkg::t_key        r_fkey,   n_fkey;
    logic [31:0]           r_fdata,  n_fdata;

    bkol_pkg::t_cell_ctl   ctl;
    bkol_pkg::t_key        cell_key  [DEPTH];
    bkol_pkg::t_payload    cell_data [DEPTH];
    logic [DEPTH:0]        prior;
    logic [DEPTH-1:0]      target;
    logic                  found, full, nonempty;
    bkol_pkg::t_key        rd_key;
    bkol_pkg::t_payload    rd_data;

    assign busy = r_busy;

    // ---- the cell row -------------------------------------------------
    assign prior[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bkol_pkg::t_key     left_key,  right_key;
        bkol_pkg::t_payload left_data, right_data;

        if (g == 0) begin : g_first
            // cell 0 never shifts from the left unless it is the target
            assign left_key  = ctl.key;
            assign left_data = ctl.data;
        end else begin : g_mid
            assign left_key  = cell_key[g-1];
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            // the last cell drops out of the list on removal
            assign right_key  = '0;
            assign right_data = '0;
        end else begin : g_inner
            assign right_key  = cell_key[g+1];
            assign right_data = cell_data[g+1];
        end

        bkol_cell u_cell (
            .i_clk        (i_clk),
            .i_idx        (bkol_pkg::IDX_W'(g)),
            .i_ctl        (ctl),
            .i_prior      (prior[g]),
            .i_left_key   (left_key),
            .i_left_data  (left_data),
            .i_right_key  (right_key),
            .i_right_data (right_data),
            .o_key        (cell_key[g]),
            .o_data       (cell_data[g]),
            .o_prior      (prior[g+1]),
            .o_target     (target[g])
        );
    end

    assign found = prior[DEPTH];

    // one-hot target read-out
    always_comb begin
        rd_key  = '0;
        rd_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (target[k]) begin
                rd_key  = rd_key  | cell_key[k];
                rd_data = rd_data | cell_data[k];
            end
        end
    end

    // ---- command decode -----------------------------------------------
    always_comb begin
        full     = r_count == bkol_pkg::CNT_W'(DEPTH);
        nonempty = r_count != '0;

        ctl.mode  = bkol_pkg::MODE_HOLD;
        ctl.mark  = bkol_pkg::MARK_NONE;
        ctl.count = r_count;
        ctl.key   = r_key;
        ctl.data  = bkol_pkg::PAYLOAD_WIDTH'(r_data);
        ctl.pos   = r_pos;

        n_count  = r_count;
        n_status = bkol_pkg::ST_MISS;
        n_fkey   = '0;
        n_fdata  = '0;

        unique case (r_func)
            bkol_pkg::F_INS_FRONT, bkol_pkg::F_INS_BACK, bkol_pkg::F_INS_SORTED: begin
                if (full) begin
                    n_status = bkol_pkg::ST_FULL;
                end else begin
                    ctl.mode = bkol_pkg::MODE_INS;
                    if (r_func == bkol_pkg::F_INS_FRONT) begin
                        ctl.mark = bkol_pkg::MARK_FRONT;
                    end else if (r_func == bkol_pkg::F_INS_BACK) begin
                        ctl.mark = bkol_pkg::MARK_TAIL;
                    end else begin
                        ctl.mark = bkol_pkg::MARK_GE_TAIL;
                    end
                    n_count  = r_count + bkol_pkg::CNT_W'(1);
                    n_status = bkol_pkg::ST_OK;
                end
            end
            bkol_pkg::F_REM_FRONT: begin
                if (nonempty) begin
                    ctl.mode = bkol_pkg::MODE_REM;
                    ctl.mark = bkol_pkg::MARK_FRONT;
                    n_count  = r_count - bkol_pkg::CNT_W'(1);
                    n_status = bkol_pkg::ST_OK;
                end
            end
            bkol_pkg::F_REM_BACK: begin
                if (nonempty) begin
                    n_count  = r_count - bkol_pkg::CNT_W'(1);
                    n_status = bkol_pkg::ST_OK;
                end
            end
            bkol_pkg::F_REM_KEY: begin
                // no match means no target, so nothing shifts
                ctl.mode = bkol_pkg::MODE_REM;
                ctl.mark = bkol_pkg::MARK_MATCH;
                if (found) begin
                    n_count  = r_count - bkol_pkg::CNT_W'(1);
                    n_status = bkol_pkg::ST_OK;
                end
            end
            bkol_pkg::F_READ_POS, bkol_pkg::F_READ_KEY: begin
                ctl.mark = (r_func == bkol_pkg::F_READ_POS) ? bkol_pkg::MARK_POS
                                                            : bkol_pkg::MARK_MATCH;
                if (found) begin
                    n_status = bkol_pkg::ST_OK;
                    n_fkey   = rd_key;
                    n_fdata  = 32'(rd_data);
                end
            end
            bkol_pkg::F_HAS_KEY: begin
                ctl.mark = bkol_pkg::MARK_MATCH;
                if (found) begin
                    n_status = bkol_pkg::ST_OK;
                end
            end
            bkol_pkg::F_CLEAR: begin
                n_count  = '0;
                n_status = bkol_pkg::ST_OK;
            end
            default: ;
        endcase

        // cells only move in the working cycle
        if (!r_busy) begin
            ctl.mode = bkol_pkg::MODE_HOLD;
        end
    end

    // ---- registers ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= r_busy;
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_func <= bkol_pkg::t_func'(i_func);
            r_key  <= i_record_key;
            r_data <= i_record_data;
            r_pos  <= i_position;
        end
        if (r_busy) begin
            r_status <= n_status;
            r_fkey   <= n_fkey;
            r_fdata  <= n_fdata;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found_key   = r_fkey;
    assign o_found_data  = r_fdata;
    assign o_entry_count = (bkol_pkg::ECNT_W)'(r_count);
    assign o_is_empty    = r_count == '0;

endmodule
